// ===== rtl/sukl_pkg.sv =====
`timescale 1ns / 1ps

package sukl_pkg;

   // Request modes
   typedef enum logic [1:0] {
      MODE_INSERT    = 2'd0,
      MODE_REMOVE    = 2'd1,
      MODE_LIST_ASC  = 2'd2,
      MODE_LIST_DESC = 2'd3
   } mode_type;

   // Result status codes
   typedef enum logic [2:0] {
      STATUS_INSERTED  = 3'd0,
      STATUS_REMOVED   = 3'd1,
      STATUS_DUPLICATE = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_FULL      = 3'd4,
      STATUS_LISTED    = 3'd5,
      STATUS_EMPTY     = 3'd6
   } status_type;

   // Operation broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_HOLD     = 3'd0,
      CELL_INSERT   = 3'd1,
      CELL_REMOVE   = 3'd2,
      CELL_ROT_ASC  = 3'd3,
      CELL_ROT_DESC = 3'd4
   } cell_op_type;

   // Top level control state
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LIST = 2'b10
   } state_type;

endpackage

// ===== rtl/sorted_unique_key_list.sv =====
`timescale 1ns / 1ps
// Insert and remove: the result is registered at the end of the transfer cycle.
// List: the list state loads the first key into the result register, then one key per
//    cycle while the result side takes them; the input waits until the last key is loaded.
// Throughput is set by the output register and the rotation of the cell chain.
// Reset clears the key count, the control state and the result valid; stored keys are
//    left as they are and only entries below the count are ever read.

module sorted_unique_key_list
   import sukl_pkg::*;
#(
   parameter int CAPACITY  = 32,
   parameter int KEY_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic        [1:0]  req_mode,
   input  logic signed [31:0] req_key,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic        [2:0]  rsp_status,
   output logic signed [31:0] rsp_key_out,
   output logic               rsp_last
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   state_type                   state_ff, state_in;
   logic        [CNT_W-1:0]     count_ff, count_in;
   logic        [CNT_W-1:0]     rem_ff, rem_in;
   logic                        desc_ff, desc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic        [2:0]           rsp_status_ff, rsp_status_in;
   logic signed [31:0]          rsp_key_ff, rsp_key_in;
   logic                        rsp_last_ff, rsp_last_in;

   cell_op_type                 op;
   logic signed [KEY_WIDTH-1:0] ins_key;
   logic signed [KEY_WIDTH-1:0] wrap_key;
   logic signed [KEY_WIDTH-1:0] tail_key;
   logic signed [KEY_WIDTH-1:0] cell_key [CAPACITY];
   logic        [CAPACITY-1:0]  below;
   logic        [CAPACITY-1:0]  equal;
   logic        [IDX_W-1:0]     tail_idx;
   logic                        out_free;
   logic                        accept;
   logic                        found;
   logic                        full;

   // Request key resized to the stored width (sign-extend or wrap)
   assign ins_key  = KEY_WIDTH'(req_key);
   assign tail_idx = IDX_W'(count_ff - CNT_W'(1));
   assign tail_key = cell_key[tail_idx];
   assign wrap_key = desc_ff ? tail_key : cell_key[0];
   assign found    = |equal;
   assign full     = count_ff == CNT_W'(CAPACITY);

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // Chain of compare-and-shift cells
   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic signed [KEY_WIDTH-1:0] left_key;
         logic signed [KEY_WIDTH-1:0] right_key;
         logic                        left_below;
         if (gi == 0) begin : g_head
            assign left_key   = wrap_key;
            assign left_below = 1'b1;
         end else begin : g_body
            assign left_key   = cell_key[gi-1];
            assign left_below = below[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_end
            assign right_key = cell_key[gi];
         end else begin : g_mid
            assign right_key = cell_key[gi+1];
         end
         sukl_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .CNT_W     (CNT_W),
            .INDEX     (gi)
         ) u_cell (
            .clock      (clock),
            .op         (op),
            .ins_key    (ins_key),
            .count      (count_ff),
            .left_key   (left_key),
            .left_below (left_below),
            .right_key  (right_key),
            .wrap_key   (wrap_key),
            .key_ff     (cell_key[gi]),
            .below      (below[gi]),
            .equal      (equal[gi])
         );
      end
   endgenerate

   // Request decode, listing sequencer and result register load
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      desc_in       = desc_ff;
      op            = CELL_HOLD;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_key_in  = req_key;
               rsp_last_in = 1'b1;
               case (req_mode)
                  MODE_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (found) begin
                        rsp_status_in = STATUS_DUPLICATE;
                     end else if (full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        rsp_status_in = STATUS_INSERTED;
                        op            = CELL_INSERT;
                        count_in      = count_ff + CNT_W'(1);
                     end
                  end
                  MODE_REMOVE: begin
                     rsp_valid_in = 1'b1;
                     if (found) begin
                        rsp_status_in = STATUS_REMOVED;
                        op            = CELL_REMOVE;
                        count_in      = count_ff - CNT_W'(1);
                     end else begin
                        rsp_status_in = STATUS_NOT_FOUND;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                        rsp_key_in    = '0;
                     end else begin
                        state_in = ST_LIST;
                        rem_in   = count_ff;
                        desc_in  = req_mode == MODE_LIST_DESC;
                     end
                  end
               endcase
            end
         end
         ST_LIST: begin
            // One key per transfer, rotating the chain back into place
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_LISTED;
               rsp_key_in    = 32'(desc_ff ? tail_key : cell_key[0]);
               rsp_last_in   = rem_ff == CNT_W'(1);
               op            = desc_ff ? CELL_ROT_DESC : CELL_ROT_ASC;
               rem_in        = rem_ff - CNT_W'(1);
               if (rem_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         desc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         desc_ff      <= desc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_key_out = rsp_key_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

// ===== rtl/sukl_cell.sv =====
`timescale 1ns / 1ps

module sukl_cell
   import sukl_pkg::*;
#(
   parameter int KEY_WIDTH = 32,
   parameter int CNT_W     = 6,
   parameter int INDEX     = 0
) (
   input  logic                        clock,
   input  cell_op_type                 op,
   input  logic signed [KEY_WIDTH-1:0] ins_key,
   input  logic        [CNT_W-1:0]     count,
   input  logic signed [KEY_WIDTH-1:0] left_key,
   input  logic                        left_below,
   input  logic signed [KEY_WIDTH-1:0] right_key,
   input  logic signed [KEY_WIDTH-1:0] wrap_key,
   output logic signed [KEY_WIDTH-1:0] key_ff,
   output logic                        below,
   output logic                        equal
);

   logic signed [KEY_WIDTH-1:0] key_in;
   logic                        occupied;
   logic                        tail;

   // Occupancy follows from the count, stored keys are sorted
   assign occupied = CNT_W'(INDEX) < count;
   assign tail     = count == CNT_W'(INDEX + 1);
   assign below    = occupied && (key_ff < ins_key);
   assign equal    = occupied && (key_ff == ins_key);

   // Next key: keep, take a neighbor, take the wrap key or take the new key
   always_comb begin
      key_in = key_ff;
      unique case (op)
         CELL_HOLD: key_in = key_ff;
         CELL_INSERT: begin
            if (!below) begin
               key_in = left_below ? ins_key : left_key;
            end
         end
         CELL_REMOVE: begin
            if (!below) begin
               key_in = right_key;
            end
         end
         CELL_ROT_ASC:  key_in = tail ? wrap_key : right_key;
         CELL_ROT_DESC: key_in = left_key;
         default:       key_in = key_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// ===== tb/sv/tb_sorted_unique_key_list.sv =====
`timescale 1ns / 1ps

module tb_sorted_unique_key_list;
   import sukl_pkg::*;

   localparam int CAPACITY    = 32;
   localparam int KEY_WIDTH   = 32;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 38;
   localparam int POOL_SIZE   = 48;

   typedef struct {
      mode_type mode;
      int       key;
      bit       drain_first;
   } key_req_type;

   typedef struct {
      status_type status;
      int         key_out;
      bit         last;
   } key_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic        [1:0]  req_mode = MODE_INSERT;
   logic signed [31:0] req_key = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic        [2:0]  rsp_status;
   logic signed [31:0] rsp_key_out;
   logic               rsp_last;

   key_req_type req_backlog[$];
   key_rsp_type expected_rsp[$];
   int          key_set[$];
   int          key_pool[POOL_SIZE];

   int  mismatches   = 0;
   int  accepted_req = 0;
   int  results_seen = 0;
   int  cycle_count  = 0;
   int  stall_left   = 0;
   bit  stall_done   = 1'b0;

   sorted_unique_key_list #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_key     (req_key),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_key_out (rsp_key_out),
      .rsp_last    (rsp_last)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void push_rsp(status_type status, int key_out, bit last);
      key_rsp_type r;
      r.status  = status;
      r.key_out = key_out;
      r.last    = last;
      expected_rsp.push_back(r);
   endfunction

   // Update the sorted key set with one request and queue the results it gives
   function automatic void apply_to_key_set(mode_type mode, int key);
      int pos;
      bit found;
      int n;
      pos = 0;
      while (pos < key_set.size() && key_set[pos] < key)
         pos++;
      found = (pos < key_set.size()) && (key_set[pos] == key);
      n = key_set.size();
      case (mode)
         MODE_INSERT: begin
            if (found) begin
               push_rsp(STATUS_DUPLICATE, key, 1'b1);
            end else if (n >= CAPACITY) begin
               push_rsp(STATUS_FULL, key, 1'b1);
            end else begin
               key_set.insert(pos, key);
               push_rsp(STATUS_INSERTED, key, 1'b1);
            end
         end
         MODE_REMOVE: begin
            if (found) begin
               key_set.delete(pos);
               push_rsp(STATUS_REMOVED, key, 1'b1);
            end else begin
               push_rsp(STATUS_NOT_FOUND, key, 1'b1);
            end
         end
         default: begin
            if (n == 0) begin
               push_rsp(STATUS_EMPTY, 0, 1'b1);
            end else begin
               for (int i = 0; i < n; i++)
                  push_rsp(STATUS_LISTED,
                           (mode == MODE_LIST_ASC) ? key_set[i] : key_set[n - 1 - i],
                           i == n - 1);
            end
         end
      endcase
   endfunction

   function automatic void add_req(mode_type mode, int key, bit drain_first = 1'b0);
      key_req_type r;
      r.mode        = mode;
      r.key         = key;
      r.drain_first = drain_first;
      req_backlog.push_back(r);
   endfunction

   // Key for insert or remove: mostly from a shared pool so that hits are common
   function automatic int pick_key();
      if ($urandom_range(99) < 75)
         return key_pool[$urandom_range(POOL_SIZE - 1)];
      return int'($urandom);
   endfunction

   // Sender: offers the backlog, predicts each transfer as it is accepted
   always @(posedge clock) begin : drive_proc
      bit          offer;
      bit          steady;
      key_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            apply_to_key_set(mode_type'(req_mode), int'(req_key));
            accepted_req++;
            offer = 1'b0;
         end
         steady = (accepted_req >= 200) && (accepted_req < 260);
         if (!offer && req_backlog.size() != 0) begin
            if (req_backlog[0].drain_first && expected_rsp.size() != 0) begin
               // wait for every outstanding result before this one
            end else if (steady || $urandom_range(99) >= IDLE_PCT) begin
               nxt = req_backlog.pop_front();
               req_mode <= nxt.mode;
               req_key  <= nxt.key;
               offer = 1'b1;
            end
         end
         req_valid <= offer;
      end
   end

   // Receiver: checks each transfer against the oldest expectation
   always @(posedge clock) begin : collect_proc
      key_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_rsp.size() == 0) begin
               $error("unexpected result: status %0d key_out %0d last %0b",
                      rsp_status, rsp_key_out, rsp_last);
               mismatches++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_key_out !== want.key_out) begin
                  $error("key_out: expected %0d, got %0d", want.key_out, rsp_key_out);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  mismatches++;
               end
            end
         end
         // one long hold-off so the block backs up into its input
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!stall_done && results_seen >= 120) begin
            stall_done = 1'b1;
            stall_left = 300;
            rsp_ready <= 1'b0;
         end else if (results_seen >= 250 && results_seen < 400) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Stimulus and end of run
   initial begin
      int phase_len[6];
      int ins_pct[6];
      int rem_pct[6];
      int r;
      mode_type m;

      key_pool[0] = 32'h7fffffff;
      key_pool[1] = 32'h80000000;
      key_pool[2] = 0;
      key_pool[3] = -1;
      key_pool[4] = 1;
      for (int i = 5; i < POOL_SIZE; i++)
         key_pool[i] = (i % 2) ? int'($urandom_range(200)) - 100 : int'($urandom);

      // directed: empty store, extremes, duplicates, both list orders
      add_req(MODE_LIST_ASC,  32'h5a5a5a5a);
      add_req(MODE_LIST_DESC, 32'ha5a5a5a5);
      add_req(MODE_REMOVE,    7);
      add_req(MODE_INSERT,    0);
      add_req(MODE_INSERT,    32'h7fffffff);
      add_req(MODE_INSERT,    32'h80000000);
      add_req(MODE_INSERT,    -1);
      add_req(MODE_INSERT,    1);
      add_req(MODE_INSERT,    0);
      add_req(MODE_INSERT,    32'h80000000);
      add_req(MODE_LIST_ASC,  0);
      add_req(MODE_LIST_DESC, -1);
      add_req(MODE_REMOVE,    32'h7fffffff);
      add_req(MODE_REMOVE,    5);
      add_req(MODE_REMOVE,    32'h80000000);
      add_req(MODE_REMOVE,    32'h80000000);
      add_req(MODE_LIST_ASC,  32'hffffffff);
      add_req(MODE_LIST_DESC, 0);

      // random: fill, mixed, drain, twice over
      phase_len = '{60, 50, 70, 60, 50, 40};
      ins_pct   = '{85, 45, 20, 85, 45, 20};
      rem_pct   = '{92, 80, 75, 92, 80, 75};
      for (int p = 0; p < 6; p++) begin
         for (int i = 0; i < phase_len[p]; i++) begin
            r = $urandom_range(99);
            if (r < ins_pct[p])
               m = MODE_INSERT;
            else if (r < rem_pct[p])
               m = MODE_REMOVE;
            else if (r % 2)
               m = MODE_LIST_ASC;
            else
               m = MODE_LIST_DESC;
            if (m == MODE_INSERT || m == MODE_REMOVE)
               add_req(m, pick_key(), p == 1 && i == 0);
            else
               add_req(m, int'($urandom), p == 1 && i == 0);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
